/* src/mfd_pkg.sv */
// Shared types and constants for the message frame deframer.
package mfd_pkg;

   localparam logic [7:0] HiNibbleMask   = 8'hf0;
   localparam logic [7:0] LoNibbleMask   = 8'h0f;
   localparam logic [7:0] FinalBitMask   = 8'h80;
   localparam logic [7:0] TypeFieldMask  = 8'h70;
   localparam logic [15:0] HeaderBytes   = 16'd4;
   localparam logic [15:0] FrameHeadBytes = 16'd2;
   localparam logic [15:0] MinFrameRoom  = 16'd2;
   localparam logic [3:0] ReplayOpcodeReset = 4'd0;

   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_FRAME     = 2'd1,
      KIND_DONE      = 2'd2,
      KIND_TOO_SHORT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_HDR  = 3'd1,
      PH_FH0  = 3'd2,
      PH_FH1  = 3'd3,
      PH_SKIP = 3'd4,
      PH_STOP = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] buffer_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [3:0]  version;
      logic [3:0]  opcode;
      logic [7:0]  msg_flags;
      logic [15:0] payload_code;
      logic [2:0]  frame_type;
      logic [11:0] frame_length;
      logic        frame_final;
      logic        complete;
      logic [15:0] bytes_left;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

endpackage

/* src/mfd_parser.sv */
// Parse state and per-byte result generation for the message frame deframer.
module mfd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  mfd_pkg::req_type  req_data,
   input  logic [3:0]        replay_opcode,
   output mfd_pkg::emit_type emit
);
   import mfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [1:0]  hpos_ff, hpos_in;
   logic [23:0] hbytes_ff, hbytes_in;
   logic [7:0]  fhead_ff, fhead_in;
   logic [11:0] skip_ff, skip_in;
   logic        complete_ff, complete_in;

   logic [15:0] rem_hdr;
   logic [15:0] rem_frame;
   logic [11:0] flen;
   logic [16:0] fneed;
   logic [11:0] skip_dec;
   logic [7:0]  b0;
   rsp_type     r0, r1;
   logic [1:0]  count;

   assign b0        = hbytes_ff[23:16];
   assign rem_hdr   = remaining_ff - HeaderBytes;
   assign flen      = {fhead_ff[3:0], req_data.data_byte};
   assign fneed     = {5'd0, flen} + {1'b0, FrameHeadBytes};
   assign rem_frame = remaining_ff - FrameHeadBytes - {4'd0, flen};
   assign skip_dec  = (skip_ff != 12'd0) ? skip_ff - 12'd1 : 12'd0;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      hpos_in      = hpos_ff;
      hbytes_in    = hbytes_ff;
      fhead_in     = fhead_ff;
      skip_in      = skip_ff;
      complete_in  = complete_ff;
      r0           = '0;
      r1           = '0;
      count        = 2'd0;
      if (take) begin
         if (req_data.first_byte) begin
            complete_in = 1'b0;
            skip_in     = '0;
            fhead_in    = '0;
            if (req_data.buffer_length < HeaderBytes) begin
               r0.result_kind = KIND_TOO_SHORT;
               count          = 2'd1;
               phase_in       = PH_STOP;
               remaining_in   = '0;
               hpos_in        = '0;
               hbytes_in      = '0;
            end else begin
               hbytes_in    = {req_data.data_byte, 16'd0};
               hpos_in      = 2'd1;
               remaining_in = req_data.buffer_length;
               phase_in     = PH_HDR;
            end
         end else begin
            case (phase_ff)
               PH_HDR: begin
                  if (hpos_ff == 2'd1) begin
                     hbytes_in[15:8] = req_data.data_byte;
                     hpos_in         = 2'd2;
                  end else if (hpos_ff == 2'd2) begin
                     hbytes_in[7:0] = req_data.data_byte;
                     hpos_in        = 2'd3;
                  end else begin
                     r0.result_kind  = KIND_HEADER;
                     r0.version      = 4'((b0 & HiNibbleMask) >> 4);
                     r0.opcode       = 4'(b0 & LoNibbleMask);
                     r0.msg_flags    = hbytes_ff[15:8];
                     r0.payload_code = {hbytes_ff[7:0], req_data.data_byte};
                     count           = 2'd1;
                     hpos_in         = '0;
                     remaining_in    = rem_hdr;
                     if (r0.opcode == replay_opcode || rem_hdr <= MinFrameRoom) begin
                        r1.result_kind = KIND_DONE;
                        r1.complete    = complete_ff;
                        r1.bytes_left  = rem_hdr;
                        count          = 2'd2;
                        phase_in       = PH_STOP;
                     end else begin
                        phase_in = PH_FH0;
                     end
                  end
               end
               PH_FH0: begin
                  fhead_in = req_data.data_byte;
                  phase_in = PH_FH1;
               end
               PH_FH1: begin
                  if (fneed > {1'b0, remaining_ff}) begin
                     r0.result_kind = KIND_DONE;
                     r0.complete    = complete_ff;
                     r0.bytes_left  = remaining_ff;
                     count          = 2'd1;
                     phase_in       = PH_STOP;
                  end else begin
                     r0.result_kind  = KIND_FRAME;
                     r0.frame_type   = 3'((fhead_ff & TypeFieldMask) >> 4);
                     r0.frame_length = flen;
                     r0.frame_final  = |(fhead_ff & FinalBitMask);
                     count           = 2'd1;
                     complete_in     = r0.frame_final;
                     remaining_in    = rem_frame;
                     if (flen == 12'd0) begin
                        if (rem_frame <= MinFrameRoom) begin
                           r1.result_kind = KIND_DONE;
                           r1.complete    = r0.frame_final;
                           r1.bytes_left  = rem_frame;
                           count          = 2'd2;
                           phase_in       = PH_STOP;
                        end else begin
                           phase_in = PH_FH0;
                        end
                     end else begin
                        skip_in  = flen;
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_dec == 12'd0) begin
                     if (remaining_ff <= MinFrameRoom) begin
                        r0.result_kind = KIND_DONE;
                        r0.complete    = complete_ff;
                        r0.bytes_left  = remaining_ff;
                        count          = 2'd1;
                        phase_in       = PH_STOP;
                     end else begin
                        phase_in = PH_FH0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
      r0.last_of_run = (count == 2'd1);
      r1.last_of_run = (count == 2'd2);
      emit.count  = count;
      emit.first  = r0;
      emit.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
         hpos_ff      <= '0;
         hbytes_ff    <= '0;
         fhead_ff     <= '0;
         skip_ff      <= '0;
         complete_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         hpos_ff      <= hpos_in;
         hbytes_ff    <= hbytes_in;
         fhead_ff     <= fhead_in;
         skip_ff      <= skip_in;
         complete_ff  <= complete_in;
      end
   end

endmodule

/* src/message_frame_deframer.sv */
// Top level of the message frame deframer: request intake, output queue and config register.
// The deframer takes one buffer byte per request and reports header, frame, done and
// too-short results. A byte is taken in every cycle while it causes at most one result
// and the output does not stall; a byte with two results (a header or zero-length frame
// followed by done) holds the request side while its second result leaves the two-entry
// output queue. Results appear in the cycle after the byte that causes them. The replay
// opcode register should be written only while no request is in flight.
module message_frame_deframer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mfd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mfd_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [3:0]       csr_wr_data
);
   import mfd_pkg::*;

   logic [3:0] replay_ff;
   logic [1:0] cnt_ff, cnt_in;
   rsp_type    q0_ff, q0_in;
   rsp_type    q1_ff, q1_in;
   logic       pop;
   logic       take;
   emit_type   emit;

   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   assign take      = req_valid && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && !rsp_stall));
   assign req_stall = !(cnt_ff == 2'd0 || (cnt_ff == 2'd1 && !rsp_stall));
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q0_ff;

   mfd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .req_data      (req_data),
      .replay_opcode (replay_ff),
      .emit          (emit)
   );

   always_comb begin
      cnt_in = cnt_ff;
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      if (take) begin
         cnt_in = emit.count;
         q0_in  = emit.first;
         q1_in  = emit.second;
      end else if (pop) begin
         if (cnt_ff == 2'd2) begin
            q0_in  = q1_ff;
            cnt_in = 2'd1;
         end else begin
            cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         replay_ff <= ReplayOpcodeReset;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_wr_en) begin
            replay_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   // A new request is taken only when the queue is empty or its last result leaves now.
   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)))
      else $error("request taken while output queue busy");

   // A result not marked last of its run must have its partner queued behind it.
   a_run_partner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_of_run) |-> (cnt_ff == 2'd2))
      else $error("result run broken in output queue");

   // Draining a full queue moves the second result to the head.
   a_shift: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && pop) |=> (cnt_ff == 2'd1 && rsp_data == $past(q1_ff)))
      else $error("second queued result lost");

   // A too-short result always stands alone.
   a_short_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_TOO_SHORT) |-> rsp_data.last_of_run)
      else $error("too-short result not last of run");

endmodule
